// File: sv/kfcs_pkg.sv
`default_nettype none

package kfcs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int COUNT_BITS  = 16;
  localparam int HALF_W      = 56;
  localparam int OCC_W       = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [HALF_W-1:0] name_high;
    logic [HALF_W-1:0] name_low;
  } req_t;

  typedef struct packed {
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
    logic [OCC_W-1:0]  occurrences;
    logic              is_entry;
    logic              overflowed;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [HALF_W-1:0]     key_high;
    logic [HALF_W-1:0]     key_low;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    SEL_KEEP,
    SEL_BUMP,
    SEL_LOAD,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_e;

endpackage

`default_nettype wire

// File: sv/kfcs_cell.sv
`default_nettype none

module kfcs_cell (
  input  wire logic               clk_i,
  input  wire kfcs_pkg::cell_sel_e sel_i,
  input  wire kfcs_pkg::req_t     req_i,
  input  wire kfcs_pkg::entry_t   left_i,
  input  wire kfcs_pkg::entry_t   right_i,
  output kfcs_pkg::entry_t        entry_o,
  output logic                    match_o
);

  kfcs_pkg::entry_t entry_q, entry_d;

  assign entry_o = entry_q;
  assign match_o = (entry_q.key_high == req_i.name_high) &&
                   (entry_q.key_low == req_i.name_low);

  always_comb begin
    entry_d = entry_q;
    case (sel_i)
      kfcs_pkg::SEL_KEEP: entry_d = entry_q;
      kfcs_pkg::SEL_BUMP: begin
        if (entry_q.count != '1) begin
          entry_d.count = entry_q.count + kfcs_pkg::COUNT_BITS'(1);
        end
      end
      kfcs_pkg::SEL_LOAD: begin
        entry_d.key_high = req_i.name_high;
        entry_d.key_low  = req_i.name_low;
        entry_d.count    = kfcs_pkg::COUNT_BITS'(1);
      end
      kfcs_pkg::SEL_LEFT:  entry_d = left_i;
      kfcs_pkg::SEL_RIGHT: entry_d = right_i;
      default:             entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// File: sv/key_frequency_count_sort.sv
`default_nettype none

// channel   | dir | handshake                         | payload
// request   | in  | start high and busy low at edge   | req_i   (kfcs_pkg::req_t)
// result    | out | res_strobe_o high for one cycle   | result_o (kfcs_pkg::rsp_t)
//
// add: the accept cycle, then an add state in which all cells match in parallel
// finish: the accept cycle, then TABLE_DEPTH odd-even transposition passes, then one
//   emit per entry (one if empty); each result shows in the cycle after its emit
// reset clears entry count and overflow flag; cells need no clearing pass
// results cannot be stalled: each is shown for exactly one cycle

module key_frequency_count_sort (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire kfcs_pkg::req_t req_i,
  output logic                res_strobe_o,
  output kfcs_pkg::rsp_t      result_o
);

  localparam int Depth = kfcs_pkg::TABLE_DEPTH;
  localparam int CntW  = kfcs_pkg::CNT_W;
  localparam int IdxW  = kfcs_pkg::IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic [IdxW-1:0] pass_q, pass_d;
  logic            ovf_q, ovf_d;
  logic            strobe_q, strobe_d;
  kfcs_pkg::req_t  req_q;
  kfcs_pkg::rsp_t  res_q, res_d;

  kfcs_pkg::entry_t    ent   [Depth];
  kfcs_pkg::entry_t    left  [Depth];
  kfcs_pkg::entry_t    right [Depth];
  kfcs_pkg::cell_sel_e sel   [Depth];
  logic [Depth-1:0]    match;
  logic [Depth-1:0]    hit_vec;
  logic [Depth-2:0]    swap;
  logic                hit;
  logic                accept;

  assign busy         = (state_q != ST_IDLE);
  assign accept       = start && !busy;
  assign res_strobe_o = strobe_q;
  assign result_o     = res_q;

  // row of cells
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left[g] = '0;
    end else begin : g_mid_l
      assign left[g] = ent[g-1];
    end
    if (g == Depth - 1) begin : g_lastc
      assign right[g] = '0;
    end else begin : g_mid_r
      assign right[g] = ent[g+1];
    end
    assign hit_vec[g] = match[g] && (CntW'(g) < count_q);

    kfcs_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel[g]),
      .req_i   (req_q),
      .left_i  (left[g]),
      .right_i (right[g]),
      .entry_o (ent[g]),
      .match_o (match[g])
    );
  end

  assign hit = |hit_vec;

  // compare-exchange on adjacent pairs, strict compare keeps ties in order
  always_comb begin
    for (int p = 0; p < Depth - 1; p++) begin
      swap[p] = (state_q == ST_SORT) && (1'(p % 2) == pass_q[0]) &&
                (CntW'(p + 1) < count_q) && (ent[p+1].count > ent[p].count);
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      sel[i] = kfcs_pkg::SEL_KEEP;
      case (state_q)
        ST_ADD: begin
          if (hit_vec[i]) begin
            sel[i] = kfcs_pkg::SEL_BUMP;
          end else if (!hit && (CntW'(i) == count_q)) begin
            sel[i] = kfcs_pkg::SEL_LOAD;
          end
        end
        ST_SORT: begin
          if (i < Depth - 1 && swap[i < Depth - 1 ? i : 0]) begin
            sel[i] = kfcs_pkg::SEL_RIGHT;
          end else if (i > 0 && swap[i > 0 ? i - 1 : 0]) begin
            sel[i] = kfcs_pkg::SEL_LEFT;
          end
        end
        ST_EMIT: begin
          if (i < Depth - 1) begin
            sel[i] = kfcs_pkg::SEL_RIGHT;
          end
        end
        default: sel[i] = kfcs_pkg::SEL_KEEP;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    pass_d   = pass_q;
    ovf_d    = ovf_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pass_d  = IdxW'(Depth - 1);
          state_d = (req_i.req_type == kfcs_pkg::REQ_FINISH) ? ST_SORT : ST_ADD;
        end
      end
      ST_ADD: begin
        if (!hit) begin
          if (count_q < CntW'(Depth)) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        state_d = ST_IDLE;
      end
      ST_SORT: begin
        pass_d = pass_q - IdxW'(1);
        if (pass_q == '0) begin
          remain_d = count_q;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_d          = 1'b1;
        res_d.is_entry    = (count_q != '0);
        res_d.key_high    = res_d.is_entry ? ent[0].key_high : '0;
        res_d.key_low     = res_d.is_entry ? ent[0].key_low : '0;
        res_d.occurrences = res_d.is_entry ? kfcs_pkg::OCC_W'(ent[0].count) : '0;
        res_d.overflowed  = ovf_q;
        res_d.last        = (remain_q <= CntW'(1));
        remain_d          = remain_q - CntW'(1);
        if (remain_q <= CntW'(1)) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      remain_q <= '0;
      pass_q   <= '0;
      ovf_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      pass_q   <= pass_d;
      ovf_q    <= ovf_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      req_q <= req_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count beyond table depth");

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q) == ST_EMIT)
    else $error("result strobe outside emit");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && res_q.last |=> !strobe_q)
    else $error("result after last transaction of run");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !res_q.is_entry |-> res_q.last)
    else $error("empty result not marked last");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && res_q.last |-> count_q == '0 && !ovf_q)
    else $error("table not cleared after finish");

endmodule

`default_nettype wire
